// ===== hw/rtl/fqc_pkg.sv =====
// Package for the clamped Q15 FIR filter.
// Holds the command and status structs between controller and datapath, and fixed widths.
// No dependencies.
package fqc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int COEF_W   = 16;
  localparam int INDEX_W  = 6;
  localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
  localparam int ACC_W    = 36;
  localparam int Q_SHIFT  = 15;
  localparam logic [SAMPLE_W-1:0] OUT_MAX = 12'd4095;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef struct packed {
    logic take;
    logic issue;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic kind_coef;
    logic enable;
    logic tap_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/fir_filter_q15_clamped.sv =====
// Top level of the clamped Q15 FIR filter.
// Joins the fqc_ctrl controller and the fqc_datapath datapath; depends on fqc_pkg.
//
// A direct-form FIR with TAPS signed Q15 coefficients over unsigned 12-bit samples.
// Each input item is either a sample or a coefficient write. A coefficient write
// gives no result; a write to a tap at or beyond TAPS is dropped. With the enable
// bit (cfg_data) clear, a sample comes back unchanged through the result and output
// registers and the delay line stays as it was. With the enable bit set, a sample
// runs through the single shared multiply-accumulate that visits one tap per cycle
// through the coefficient and delay line memories, followed by a two-stage pipeline
// drain. The exact sum is shifted right by 15 and clamped to 0..4095. One item is
// processed at a time; a finished result waits in the output register without
// stopping intake of the next item. Configuration is always ready and should only
// be written while the block is idle.
module fir_filter_q15_clamped #(
  parameter int TAPS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [fqc_pkg::SAMPLE_W-1:0]        sample,
  input  logic [fqc_pkg::INDEX_W-1:0]         coef_index,
  input  logic signed [fqc_pkg::COEF_W-1:0]   coef_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fqc_pkg::SAMPLE_W-1:0]        filtered
);

  fqc_pkg::cmd_t cmd;
  fqc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  fqc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fqc_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .sample     (sample),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .filtered   (filtered),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== hw/rtl/fqc_ctrl.sv =====
// Controller state machine of the clamped Q15 FIR filter.
// Sequences item intake, the tap loop, pipeline drain and result hand-off.
// Depends on fqc_pkg.
module fqc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fqc_pkg::sts_t sts,
  output fqc_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.kind_coef) begin
            state_next = S_IDLE;
          end else if (sts.enable) begin
            state_next = S_RUN;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (sts.tap_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A result is never written over one that has not been taken.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded while output register occupied");

  // The last tap issue leads into the drain phase.
  a_run_to_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && sts.tap_last) |=> (state == S_DRAIN))
    else $error("tap loop did not end after the last tap");

endmodule

// ===== hw/rtl/fqc_datapath.sv =====
// Datapath of the clamped Q15 FIR filter: delay line and coefficient memories,
// the shared multiply-accumulate pipeline, clamping and the output register.
// Depends on fqc_pkg.
module fqc_datapath #(
  parameter int TAPS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_data,
  input  logic                                kind,
  input  logic [fqc_pkg::SAMPLE_W-1:0]        sample,
  input  logic [fqc_pkg::INDEX_W-1:0]         coef_index,
  input  logic signed [fqc_pkg::COEF_W-1:0]   coef_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fqc_pkg::SAMPLE_W-1:0]        filtered,
  input  fqc_pkg::cmd_t                       cmd,
  output fqc_pkg::sts_t                       sts
);

  localparam int AW = $clog2(TAPS);

  logic                               enable;
  logic [AW-1:0]                      pos;
  logic [AW-1:0]                      pos_next;
  logic [AW-1:0]                      tap;
  logic [AW:0]                        slot_sum;
  logic [AW-1:0]                      slot;
  logic [AW-1:0]                      coef_wa;
  logic                               coef_we;
  logic                               dly_we;
  logic                               take_filter;
  logic                               take_bypass;

  logic [fqc_pkg::COEF_W-1:0]         coef_mem [TAPS];
  logic [fqc_pkg::SAMPLE_W-1:0]       dly_mem [TAPS];
  logic [TAPS-1:0]                    coef_vld;
  logic [TAPS-1:0]                    dly_vld;

  logic [fqc_pkg::COEF_W-1:0]         coef_rd;
  logic [fqc_pkg::SAMPLE_W-1:0]       dly_rd;
  logic                               coef_rv;
  logic                               dly_rv;
  logic                               rd_v;
  logic signed [fqc_pkg::COEF_W-1:0]  coef_eff;
  logic [fqc_pkg::SAMPLE_W-1:0]       dly_eff;
  logic signed [fqc_pkg::PROD_W-1:0]  prod;
  logic                               prod_v;
  logic signed [fqc_pkg::ACC_W-1:0]   acc;
  logic [fqc_pkg::ACC_W-2-fqc_pkg::Q_SHIFT:0] acc_q;
  logic [fqc_pkg::SAMPLE_W-1:0]       clamped;
  logic [fqc_pkg::SAMPLE_W-1:0]       res;

  assign take_filter = cmd.take && (kind == fqc_pkg::KIND_SAMPLE) && enable;
  assign take_bypass = cmd.take && (kind == fqc_pkg::KIND_SAMPLE) && !enable;
  assign coef_wa     = AW'(coef_index);
  assign coef_we     = cmd.take && (kind == fqc_pkg::KIND_COEF) && (32'(coef_index) < TAPS);
  assign dly_we      = take_filter;
  assign pos_next    = (pos == '0) ? AW'(TAPS - 1) : pos - AW'(1);

  assign slot_sum = {1'b0, pos} + {1'b0, tap};
  assign slot     = (slot_sum >= (AW + 1)'(TAPS)) ? AW'(slot_sum - (AW + 1)'(TAPS))
                                                   : slot_sum[AW-1:0];

  assign sts.kind_coef = (kind == fqc_pkg::KIND_COEF);
  assign sts.enable    = enable;
  assign sts.tap_last  = (tap == AW'(TAPS - 1));
  assign sts.pipe_busy = rd_v || prod_v;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_valid) begin
      enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      coef_vld <= '0;
      dly_vld  <= '0;
    end else begin
      if (dly_we) begin
        pos               <= pos_next;
        dly_vld[pos_next] <= 1'b1;
      end
      if (coef_we) begin
        coef_vld[coef_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_value;
    end
    if (dly_we) begin
      dly_mem[pos_next] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    coef_rd <= coef_mem[tap];
    dly_rd  <= dly_mem[slot];
    coef_rv <= coef_vld[tap];
    dly_rv  <= dly_vld[slot];
  end

  always_ff @(posedge clk) begin
    if (take_filter) begin
      tap <= '0;
    end else if (cmd.issue) begin
      tap <= tap + AW'(1);
    end
  end

  assign coef_eff = coef_rv ? $signed(coef_rd) : '0;
  assign dly_eff  = dly_rv ? dly_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= cmd.issue;
      prod_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef_eff * $signed({1'b0, dly_eff});
  end

  always_ff @(posedge clk) begin
    if (take_filter) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + fqc_pkg::ACC_W'(prod);
    end
  end

  assign acc_q = acc[fqc_pkg::ACC_W-2:fqc_pkg::Q_SHIFT];

  always_comb begin
    if (acc[fqc_pkg::ACC_W-1]) begin
      clamped = '0;
    end else if (acc_q > ($bits(acc_q))'(fqc_pkg::OUT_MAX)) begin
      clamped = fqc_pkg::OUT_MAX;
    end else begin
      clamped = acc_q[fqc_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (take_bypass) begin
      res <= sample;
    end else if (cmd.finish) begin
      res <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered <= res;
    end
  end

  // No new item is taken while products are still in flight.
  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    sts.pipe_busy |-> !cmd.take)
    else $error("item taken while accumulation pipeline busy");

  // A filtered sample restarts the tap loop and moves the newest slot.
  a_filter_start: assert property (@(posedge clk) disable iff (rst)
    take_filter |=> (tap == '0) && (pos != $past(pos)))
    else $error("filter start did not reset tap loop or advance delay line");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for fir_filter_q15_clamped: a built-in predictor follows
// every tap write, config write and sample, and each output item is checked in order.
// Depends on fqc_pkg and the fir_filter_q15_clamped RTL only.
module tb_top;

  localparam int TAPS          = 64;
  localparam int SETTLE_CYCLES = TAPS + 8;
  localparam int STALL_CYCLES  = 500;
  localparam int SAMPLE_W      = fqc_pkg::SAMPLE_W;
  localparam int INDEX_W       = fqc_pkg::INDEX_W;
  localparam int COEF_W        = fqc_pkg::COEF_W;

  typedef enum int {
    PROF_AVERAGE,
    PROF_SMALL,
    PROF_FULL
  } coef_profile_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic                       cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       kind;
  logic [SAMPLE_W-1:0]        sample;
  logic [INDEX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic                       out_valid;
  logic                       out_ready;
  logic [SAMPLE_W-1:0]        filtered;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_request = 1'b0;
  int errors        = 0;
  int n_filtered    = 0;
  int n_bypassed    = 0;
  int n_tap_writes  = 0;
  int n_clamp_low   = 0;
  int n_clamp_high  = 0;

  logic signed [COEF_W-1:0] tap_coef [TAPS];
  logic [SAMPLE_W-1:0]      history [TAPS];
  int                       newest_slot;
  logic                     filter_on;
  logic [SAMPLE_W-1:0]      expected_filtered [$];
  coef_profile_t            profile;

  fir_filter_q15_clamped #(
    .TAPS(TAPS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .sample    (sample),
    .coef_index(coef_index),
    .coef_value(coef_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered)
  );

  always #5 clk = ~clk;

  function automatic logic [SAMPLE_W-1:0] convolve(input logic [SAMPLE_W-1:0] s);
    longint acc;
    longint shifted;
    int     slot;
    acc = 0;
    newest_slot = (newest_slot == 0) ? TAPS - 1 : newest_slot - 1;
    history[newest_slot] = s;
    slot = newest_slot;
    for (int k = 0; k < TAPS; k++) begin
      acc += longint'(tap_coef[k]) * longint'(history[slot]);
      slot = (slot == TAPS - 1) ? 0 : slot + 1;
    end
    if (acc < 0) begin
      n_clamp_low++;
      return '0;
    end
    shifted = acc >>> fqc_pkg::Q_SHIFT;
    if (shifted > fqc_pkg::OUT_MAX) begin
      n_clamp_high++;
      return fqc_pkg::OUT_MAX;
    end
    return shifted[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin : scoreboard
    logic [SAMPLE_W-1:0] want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_filtered.size() == 0) begin
          $error("filtered: expected no item, actual %0d", filtered);
          errors++;
        end else begin
          want = expected_filtered.pop_front();
          if (filtered !== want) begin
            $error("filtered: expected %0d, actual %0d", want, filtered);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        filter_on = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (kind == fqc_pkg::KIND_COEF) begin
          tap_coef[coef_index] = coef_value;
          n_tap_writes++;
        end else if (filter_on) begin
          expected_filtered.push_back(convolve(sample));
          n_filtered++;
        end else begin
          expected_filtered.push_back(sample);
          n_bypassed++;
        end
      end
    end
  end

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        repeat (STALL_CYCLES) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic k, input logic [SAMPLE_W-1:0] s,
                           input logic [INDEX_W-1:0] idx, input logic [COEF_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    sample     <= s;
    coef_index <= idx;
    coef_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    send_item(fqc_pkg::KIND_SAMPLE, s, INDEX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coef(input logic [INDEX_W-1:0] idx, input logic [COEF_W-1:0] v);
    send_item(fqc_pkg::KIND_COEF, SAMPLE_W'($urandom), idx, v);
  endtask

  task automatic finish_stream();
    in_valid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic en);
    finish_stream();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return fqc_pkg::OUT_MAX;
      default: return SAMPLE_W'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(input coef_profile_t p);
    int v;
    case (p)
      PROF_AVERAGE: v = 512 + int'($urandom_range(64)) - 32;
      PROF_SMALL:   v = int'($urandom_range(4095)) - 2048;
      default: begin
        case ($urandom_range(7))
          0:       v = -32768;
          1:       v = 32767;
          default: v = int'($urandom);
        endcase
      end
    endcase
    return COEF_W'(v);
  endfunction

  task automatic load_profile(input coef_profile_t p);
    for (int k = 0; k < TAPS; k++) begin
      send_coef(INDEX_W'(k), pick_coef(p));
    end
  endtask

  task automatic test_bypass_corners();
    send_sample('0);
    send_sample(fqc_pkg::OUT_MAX);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_coef(INDEX_W'(0), 16'h7FFF);
  endtask

  task automatic test_filter_corners();
    write_enable(1'b1);
    send_coef(INDEX_W'(0), 16'h8000);
    send_sample(fqc_pkg::OUT_MAX);
    send_coef(INDEX_W'(0), 16'h7FFF);
    send_coef(INDEX_W'(1), 16'h7FFF);
    send_sample(fqc_pkg::OUT_MAX);
    send_coef(INDEX_W'(42), 16'h5555);
    send_coef(INDEX_W'(21), 16'hAAAA);
    send_coef(INDEX_W'(63), 16'hFFFF);
    send_sample(12'h555);
    send_sample(12'hAAA);
    send_sample('0);
  endtask

  task automatic test_bypass_keeps_history();
    write_enable(1'b0);
    send_sample(12'd1234);
    send_sample(fqc_pkg::OUT_MAX);
    write_enable(1'b1);
    send_sample('0);
  endtask

  task automatic test_random_traffic(input int n_items, input int snd_pct,
                                     input int rcv_pct, input logic en);
    int sent;
    int pick;
    int burst;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    write_enable(en);
    profile = coef_profile_t'($urandom_range(2));
    load_profile(profile);
    sent = TAPS;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        profile = coef_profile_t'($urandom_range(2));
        load_profile(profile);
        sent += TAPS;
      end else if (pick < 30) begin
        burst = $urandom_range(6, 1);
        repeat (burst) send_coef(INDEX_W'($urandom), pick_coef(profile));
        sent += burst;
      end else begin
        burst = $urandom_range(24, 1);
        repeat (burst) send_sample(pick_sample());
        sent += burst;
      end
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_enable(1'b1);
    @(negedge clk);
    stall_request = 1'b1;
    @(posedge clk);
    repeat (24) send_sample(pick_sample());
  endtask

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    in_valid   = 1'b0;
    kind       = fqc_pkg::KIND_SAMPLE;
    sample     = '0;
    coef_index = '0;
    coef_value = '0;
    for (int k = 0; k < TAPS; k++) begin
      tap_coef[k] = '0;
      history[k]  = '0;
    end
    newest_slot = 0;
    filter_on   = 1'b0;
    profile     = PROF_AVERAGE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_bypass_corners();
    test_filter_corners();
    test_bypass_keeps_history();
    test_random_traffic(500, 18, 74, 1'b1);
    test_random_traffic(100, 18, 74, 1'b0);
    test_random_traffic(500, 74, 18, 1'b1);
    test_random_traffic(500, 0, 0, 1'b1);
    test_output_backpressure();
    finish_stream();

    $display("Checked %0d filtered items (%0d clamped at zero, %0d at full scale)",
             n_filtered, n_clamp_low, n_clamp_high);
    $display("and %0d bypassed, with %0d tap writes and a %0d-cycle output stall.",
             n_bypassed, n_tap_writes, STALL_CYCLES);
    if (errors == 0) begin
      $display("fir_filter_q15_clamped regression: pass");
    end else begin
      $display("fir_filter_q15_clamped regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("fir_filter_q15_clamped regression: fail");
    $finish;
  end

endmodule
